// ===== sv/epaper_dirty_region_refresh_policy_macros.svh =====
// assertion helpers shared by the refresh policy block
`ifndef EPAPER_DIRTY_REGION_REFRESH_POLICY_MACROS_SVH
`define EPAPER_DIRTY_REGION_REFRESH_POLICY_MACROS_SVH

// same-cycle property, checked outside reset
`define EDRRP_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// condition now implies a consequence in the next cycle, checked outside reset
`define EDRRP_ASSERT_NEXT(name, pre, post, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) pre |=> post) else $error(msg);

`endif

// ===== sv/edrrp_pkg.sv =====
package edrrp_pkg;

  // input item modes
  localparam logic [2:0] MODE_MARK     = 3'd0;
  localparam logic [2:0] MODE_CLIP     = 3'd1;
  localparam logic [2:0] MODE_FLUSH    = 3'd2;
  localparam logic [2:0] MODE_REQ_FULL = 3'd3;
  localparam logic [2:0] MODE_CLEAR    = 3'd4;
  localparam logic [2:0] MODE_FULL     = 3'd5;

  // refresh kinds in a result item
  localparam logic [1:0] KIND_NONE = 2'd0;
  localparam logic [1:0] KIND_FULL = 2'd1;
  localparam logic [1:0] KIND_FAST = 2'd2;

  // configuration register indexes
  localparam logic [2:0] REG_MARGIN_LEFT   = 3'd0;
  localparam logic [2:0] REG_MARGIN_TOP    = 3'd1;
  localparam logic [2:0] REG_PANEL_WIDTH   = 3'd2;
  localparam logic [2:0] REG_PANEL_HEIGHT  = 3'd3;
  localparam logic [2:0] REG_FULL_INTERVAL = 3'd4;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 11;

  // register reset values
  localparam logic [10:0] PANEL_WIDTH_RST   = 11'd800;
  localparam logic [10:0] PANEL_HEIGHT_RST  = 11'd480;
  localparam logic [7:0]  FULL_INTERVAL_RST = 8'd30;

  // fast refresh count saturates here
  localparam logic [7:0] COUNT_MAX = 8'd255;

  typedef struct packed {
    logic [2:0]         mode;
    logic signed [11:0] rect_x;
    logic signed [11:0] rect_y;
    logic signed [11:0] rect_w;
    logic signed [11:0] rect_h;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  refresh_kind;
    logic [10:0] region_x0;
    logic [10:0] region_y0;
    logic [10:0] region_x1;
    logic [10:0] region_y1;
    logic [7:0]  fast_count;
  } out_item_t;

endpackage

// ===== sv/epaper_dirty_region_refresh_policy.sv =====
// Dirty region refresh policy: marks are offset by the margins, clamped to the panel and
// merged into a bounding box; a flush intersects the box with the one-shot clip and picks
// no, full or fast refresh. Every item yields one result item. The block takes one item per
// clock while the output is not stalled: an item sits in the input register, its whole effect
// on the stored box, clip, flags and fast count is worked out combinationally there, and the
// result is registered in the output register. The update of the stored state, including
// the area multiply and compare, is combinational, which sets that rate. A stalled output
// holds the result and the input register; the input stalls only while both are full.
`include "epaper_dirty_region_refresh_policy_macros.svh"

module epaper_dirty_region_refresh_policy #(
  parameter int COORD_BITS = 11
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [edrrp_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [edrrp_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  edrrp_pkg::in_item_t                  in_item_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output edrrp_pkg::out_item_t                 out_item_o
);

  // working width for signed coordinate math
  localparam int WW    = ((COORD_BITS > 14) ? COORD_BITS : 14) + 1;
  localparam int DW    = COORD_BITS + 1;
  localparam int CMP_W = ((2 * DW + 2) > 24) ? (2 * DW + 2) : 24;

  typedef logic signed [WW-1:0] work_t;

  // configuration registers
  logic [7:0]  margin_left_q, margin_top_q, full_interval_q;
  logic [10:0] panel_width_q, panel_height_q;

  // pipeline registers
  logic                 s1_valid_q;
  edrrp_pkg::in_item_t  s1_q;
  logic                 out_valid_q;
  edrrp_pkg::out_item_t out_q;
  logic                 s1_adv, in_acc, proc;

  // policy state
  logic                  dirty_valid_q, dirty_valid_d;
  logic [COORD_BITS-1:0] dirty_q [4];
  logic [COORD_BITS-1:0] dirty_d [4];
  logic                  clip_valid_q, clip_valid_d;
  logic [COORD_BITS-1:0] clip_q [4];
  logic [COORD_BITS-1:0] clip_d [4];
  logic                  force_full_q, force_full_d;
  logic                  init_q, init_d;
  logic [7:0]            cnt_q, cnt_d;

  // combinational working signals
  work_t                 ox, oy, mx, my, mw, mh, pw, ph;
  work_t                 mk_x0, mk_y0, mk_x1e, mk_y1e, mk_x1, mk_y1;
  work_t                 st_x0, st_y0, st_x1, st_y1;
  work_t                 cx0, cy0, cx1, cy1;
  logic                  mark_en, mk_ok, dv_m, fl_en, cv, ff, fl_empty, huge, full;
  logic [COORD_BITS-1:0] bm [4];
  logic [COORD_BITS-1:0] fx0, fy0, fx1, fy1;
  logic [DW-1:0]         dx, dy;
  logic [2*DW-1:0]       area;
  logic [21:0]           panel_prod;
  logic [23:0]           panel3;
  edrrp_pkg::out_item_t  res;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      margin_left_q   <= '0;
      margin_top_q    <= '0;
      panel_width_q   <= edrrp_pkg::PANEL_WIDTH_RST;
      panel_height_q  <= edrrp_pkg::PANEL_HEIGHT_RST;
      full_interval_q <= edrrp_pkg::FULL_INTERVAL_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        edrrp_pkg::REG_MARGIN_LEFT:   margin_left_q   <= cfg_data_i[7:0];
        edrrp_pkg::REG_MARGIN_TOP:    margin_top_q    <= cfg_data_i[7:0];
        edrrp_pkg::REG_PANEL_WIDTH:   panel_width_q   <= cfg_data_i[10:0];
        edrrp_pkg::REG_PANEL_HEIGHT:  panel_height_q  <= cfg_data_i[10:0];
        edrrp_pkg::REG_FULL_INTERVAL: full_interval_q <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // handshake: input register moves on when the output register is free or draining
  assign s1_adv     = !out_valid_q || !out_stall_i;
  assign in_stall_o = s1_valid_q && !s1_adv;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign proc       = s1_valid_q && s1_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_acc) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_q <= in_item_i;
    end
  end

  // mark rectangle: offset, clamp and merge into the dirty box
  always_comb begin
    ox = work_t'(s1_q.rect_x) + work_t'(margin_left_q);
    oy = work_t'(s1_q.rect_y) + work_t'(margin_top_q);
    pw = work_t'(panel_width_q);
    ph = work_t'(panel_height_q);
    mark_en = (s1_q.mode == edrrp_pkg::MODE_MARK) || (s1_q.mode == edrrp_pkg::MODE_CLEAR) ||
              (s1_q.mode == edrrp_pkg::MODE_FULL);
    if (s1_q.mode == edrrp_pkg::MODE_MARK) begin
      mx = ox;
      my = oy;
      mw = work_t'(s1_q.rect_w);
      mh = work_t'(s1_q.rect_h);
    end else begin
      mx = '0;
      my = '0;
      mw = pw;
      mh = ph;
    end
    mk_x0  = (mx > work_t'(0)) ? mx : work_t'(0);
    mk_y0  = (my > work_t'(0)) ? my : work_t'(0);
    mk_x1e = (pw < mx + mw) ? pw : mx + mw;
    mk_y1e = (ph < my + mh) ? ph : my + mh;
    mk_x1  = mk_x1e - work_t'(1);
    mk_y1  = mk_y1e - work_t'(1);
    mk_ok  = mark_en && (mw > work_t'(0)) && (mh > work_t'(0)) &&
             (mk_x1e > mk_x0) && (mk_y1e > mk_y0);
    st_x0  = work_t'(dirty_q[0]);
    st_y0  = work_t'(dirty_q[1]);
    st_x1  = work_t'(dirty_q[2]);
    st_y1  = work_t'(dirty_q[3]);
    if (!mk_ok) begin
      bm = dirty_q;
    end else if (!dirty_valid_q) begin
      bm[0] = COORD_BITS'(mk_x0);
      bm[1] = COORD_BITS'(mk_y0);
      bm[2] = COORD_BITS'(mk_x1);
      bm[3] = COORD_BITS'(mk_y1);
    end else begin
      bm[0] = COORD_BITS'((st_x0 < mk_x0) ? st_x0 : mk_x0);
      bm[1] = COORD_BITS'((st_y0 < mk_y0) ? st_y0 : mk_y0);
      bm[2] = COORD_BITS'((st_x1 > mk_x1) ? st_x1 : mk_x1);
      bm[3] = COORD_BITS'((st_y1 > mk_y1) ? st_y1 : mk_y1);
    end
    dv_m = dirty_valid_q || mk_ok;
  end

  // clip rectangle clamp
  always_comb begin
    cx0 = (ox > work_t'(0)) ? ox : work_t'(0);
    cy0 = (oy > work_t'(0)) ? oy : work_t'(0);
    cx1 = (pw - work_t'(1) < ox + work_t'(s1_q.rect_w) - work_t'(1)) ?
          pw - work_t'(1) : ox + work_t'(s1_q.rect_w) - work_t'(1);
    cy1 = (ph - work_t'(1) < oy + work_t'(s1_q.rect_h) - work_t'(1)) ?
          ph - work_t'(1) : oy + work_t'(s1_q.rect_h) - work_t'(1);
  end

  // flush: intersect with the clip, area test and refresh choice
  always_comb begin
    fl_en = (s1_q.mode == edrrp_pkg::MODE_FLUSH) || (s1_q.mode == edrrp_pkg::MODE_FULL);
    cv    = clip_valid_q && (s1_q.mode != edrrp_pkg::MODE_FULL);
    ff    = force_full_q || (s1_q.mode == edrrp_pkg::MODE_FULL);
    fx0   = (cv && (clip_q[0] > bm[0])) ? clip_q[0] : bm[0];
    fy0   = (cv && (clip_q[1] > bm[1])) ? clip_q[1] : bm[1];
    fx1   = (cv && (clip_q[2] < bm[2])) ? clip_q[2] : bm[2];
    fy1   = (cv && (clip_q[3] < bm[3])) ? clip_q[3] : bm[3];
    fl_empty   = (fx1 < fx0) || (fy1 < fy0);
    dx         = DW'(fx1) - DW'(fx0) + DW'(1);
    dy         = DW'(fy1) - DW'(fy0) + DW'(1);
    area       = (2 * DW)'(dx) * (2 * DW)'(dy);
    panel_prod = 22'(panel_width_q) * 22'(panel_height_q);
    panel3     = {1'b0, panel_prod, 1'b0} + 24'(panel_prod);
    huge       = CMP_W'({area, 2'b00}) > CMP_W'(panel3);
    full       = init_q || ff || huge || (cnt_q >= full_interval_q);
  end

  // next state and result item
  always_comb begin
    dirty_valid_d = dirty_valid_q;
    dirty_d       = dirty_q;
    clip_valid_d  = clip_valid_q;
    clip_d        = clip_q;
    force_full_d  = force_full_q;
    init_d        = init_q;
    cnt_d         = cnt_q;
    res           = '0;
    res.refresh_kind = edrrp_pkg::KIND_NONE;

    // per-mode updates before any flush
    unique case (s1_q.mode)
      edrrp_pkg::MODE_MARK: begin
        dirty_valid_d = dv_m;
        dirty_d       = bm;
      end
      edrrp_pkg::MODE_CLIP: begin
        if ((s1_q.rect_w <= 12'sd0) || (s1_q.rect_h <= 12'sd0)) begin
          clip_valid_d = 1'b0;
        end else if ((cx1 >= cx0) && (cy1 >= cy0)) begin
          clip_d[0]    = COORD_BITS'(cx0);
          clip_d[1]    = COORD_BITS'(cy0);
          clip_d[2]    = COORD_BITS'(cx1);
          clip_d[3]    = COORD_BITS'(cy1);
          clip_valid_d = 1'b1;
        end else begin
          clip_valid_d = 1'b0;
        end
      end
      edrrp_pkg::MODE_REQ_FULL: begin
        force_full_d = 1'b1;
      end
      edrrp_pkg::MODE_CLEAR: begin
        dirty_valid_d = dv_m;
        dirty_d       = bm;
        force_full_d  = 1'b1;
      end
      edrrp_pkg::MODE_FULL: begin
        dirty_valid_d = dv_m;
        dirty_d       = bm;
        force_full_d  = 1'b1;
        clip_valid_d  = 1'b0;
      end
      default: ;
    endcase

    // flush of a dirty region
    if (fl_en && dv_m) begin
      dirty_valid_d = 1'b0;
      clip_valid_d  = 1'b0;
      force_full_d  = 1'b0;
      if (!fl_empty) begin
        if (full) begin
          res.refresh_kind = edrrp_pkg::KIND_FULL;
          cnt_d            = '0;
          init_d           = 1'b0;
        end else begin
          res.refresh_kind = edrrp_pkg::KIND_FAST;
          if (cnt_q != edrrp_pkg::COUNT_MAX) begin
            cnt_d = cnt_q + 8'd1;
          end
        end
        res.region_x0 = 11'(fx0);
        res.region_y0 = 11'(fy0);
        res.region_x1 = 11'(fx1);
        res.region_y1 = 11'(fy1);
      end
    end
    res.fast_count = cnt_d;
  end

  // policy state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dirty_valid_q <= 1'b0;
      dirty_q       <= '{default: '0};
      clip_valid_q  <= 1'b0;
      clip_q        <= '{default: '0};
      force_full_q  <= 1'b1;
      init_q        <= 1'b1;
      cnt_q         <= '0;
    end else if (proc) begin
      dirty_valid_q <= dirty_valid_d;
      dirty_q       <= dirty_d;
      clip_valid_q  <= clip_valid_d;
      clip_q        <= clip_d;
      force_full_q  <= force_full_d;
      init_q        <= init_d;
      cnt_q         <= cnt_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (proc) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (proc) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // checks
  `EDRRP_ASSERT(a_init_clears_on_full, $fell(init_q) |-> out_valid_q && (out_q.refresh_kind == edrrp_pkg::KIND_FULL), "initial full pending cleared without a full refresh")
  `EDRRP_ASSERT(a_fast_counts, out_valid_q && (out_q.refresh_kind == edrrp_pkg::KIND_FAST) |-> out_q.fast_count != 8'd0, "fast refresh reported with zero count")
  `EDRRP_ASSERT(a_none_zero_region, out_valid_q && (out_q.refresh_kind == edrrp_pkg::KIND_NONE) |-> (out_q.region_x0 == 11'd0) && (out_q.region_y0 == 11'd0) && (out_q.region_x1 == 11'd0) && (out_q.region_y1 == 11'd0), "region not zero on no refresh")
  `EDRRP_ASSERT_NEXT(a_s1_holds, s1_valid_q && !s1_adv, s1_valid_q && $stable(s1_q), "input register changed while blocked")

endmodule
